### rtl/umreu_pkg.sv
// ----------------------------------------------------------------------------
// umreu_pkg
// Types and constants shared by the register execute unit and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package umreu_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int WORD_W    = 32;
    localparam int DIV_CW    = $clog2(WORD_W);

    // opcodes, instruction bits 31-28
    localparam logic [3:0] OP_CMOV    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_STORE   = 4'd2;
    localparam logic [3:0] OP_ADD     = 4'd3;
    localparam logic [3:0] OP_MUL     = 4'd4;
    localparam logic [3:0] OP_DIV     = 4'd5;
    localparam logic [3:0] OP_NAND    = 4'd6;
    localparam logic [3:0] OP_HALT    = 4'd7;
    localparam logic [3:0] OP_MAP     = 4'd8;
    localparam logic [3:0] OP_ABANDON = 4'd9;
    localparam logic [3:0] OP_OUT     = 4'd10;
    localparam logic [3:0] OP_IN      = 4'd11;
    localparam logic [3:0] OP_LOADP   = 4'd12;
    localparam logic [3:0] OP_LDI     = 4'd13;

    // result kinds
    localparam logic [3:0] K_NONE     = 4'd0;
    localparam logic [3:0] K_OUT      = 4'd1;
    localparam logic [3:0] K_LOAD     = 4'd2;
    localparam logic [3:0] K_STORE    = 4'd3;
    localparam logic [3:0] K_MAP      = 4'd4;
    localparam logic [3:0] K_UNMAP    = 4'd5;
    localparam logic [3:0] K_LOADP    = 4'd6;
    localparam logic [3:0] K_HALT     = 4'd7;
    localparam logic [3:0] K_DIVFAULT = 4'd8;

    localparam logic ACT_EXEC  = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] instr_word;
        logic [7:0]        in_char;
        logic              in_eof;
        logic [REG_AW-1:0] reply_reg;
        logic [WORD_W-1:0] reply_value;
    } t_req;

    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        char_out;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [WORD_W-1:0] operand_c;
        logic [REG_AW-1:0] dest_reg;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_C,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WRB,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/umreu_req_if.sv
// ----------------------------------------------------------------------------
// umreu_req_if
// Request channel: instruction words and memory reply write-backs.
// ----------------------------------------------------------------------------
`default_nettype none

interface umreu_req_if;
    logic             valid;
    logic             ready;
    umreu_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/umreu_rsp_if.sv
// ----------------------------------------------------------------------------
// umreu_rsp_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface umreu_rsp_if;
    logic             valid;
    logic             ready;
    umreu_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/umreu_ram.sv
// ----------------------------------------------------------------------------
// umreu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module umreu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/um_register_execute_unit.sv
// ----------------------------------------------------------------------------
// um_register_execute_unit
// Register side of the 32-bit Universal Machine: eight registers, local ALU
// operations, memory and I/O operations reported as results.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries either an instruction word (action 0) or a memory reply
//   to be written into a register (action 1). Each request gives exactly one
//   result on o_rsp, in order. Load, store, map, unmap, load program, output,
//   halt and divide by zero are reported there; the caller answers loads and
//   maps with a write-back request to dest_reg.
//   A write-back request goes straight to the result. An instruction makes
//   three register reads through the single read port, then executes;
//   multiply and divide add a write-back step, divide first running one
//   quotient bit per cycle in its own subtractor. The unit takes the next
//   request in the cycle after the result is moved to the output register.
//   Results sit in an output register; a stalled receiver holds it while the
//   unit accepts and works on the next request, which then waits for the slot.
//   Reset (synchronous, active low) clears all registers to zero through
//   per-register valid bits and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module um_register_execute_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    umreu_req_if.sink       i_req,
    umreu_rsp_if.source     o_rsp
);

    import umreu_pkg::*;

    t_state              r_state, n_state;
    t_req                r_item, n_item;
    logic [WORD_W-1:0]   r_vb, n_vb;
    logic [WORD_W-1:0]   r_vc, n_vc;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [DIV_CW-1:0]   r_cnt, n_cnt;
    t_rsp                r_res, n_res;
    t_rsp                r_out;
    logic                r_out_valid, n_out_valid;
    logic [REG_COUNT-1:0] r_valid;
    logic [REG_AW-1:0]   r_rd_addr;

    logic                accept;
    logic                ld_out;
    logic                wr_en;
    logic [REG_AW-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [REG_AW-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   rd_m;
    logic [3:0]          op;
    logic [REG_AW-1:0]   ra, rb, rc;
    logic [WORD_W-1:0]   mul_lo;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;

    umreu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_m   = r_valid[r_rd_addr] ? rd_data : '0;
    assign op     = r_item.instr_word[31:28];
    assign ra     = r_item.instr_word[8:6];
    assign rb     = r_item.instr_word[5:3];
    assign rc     = r_item.instr_word[2:0];
    assign mul_lo = r_vb * r_vc;
    assign trial  = {r_rem, r_acc[WORD_W-1]};
    assign diff   = trial - {1'b0, r_vc};

    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out;

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_vb    = r_vb;
        n_vc    = r_vc;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_res   = r_res;
        ld_out  = 1'b0;
        wr_en   = 1'b0;
        wr_addr = ra;
        wr_data = '0;
        rd_addr = rb;
        case (r_state)
            S_IDLE: begin
                rd_addr = i_req.data.instr_word[5:3];
                if (accept) begin
                    n_item = i_req.data;
                    n_res  = '0;
                    if (i_req.data.action == ACT_REPLY) begin
                        wr_en   = 1'b1;
                        wr_addr = i_req.data.reply_reg;
                        wr_data = i_req.data.reply_value;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD_C;
                    end
                end
            end
            S_RD_C: begin
                n_vb    = rd_m;
                rd_addr = rc;
                n_state = S_RD_A;
            end
            S_RD_A: begin
                n_vc    = rd_m;
                rd_addr = ra;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                case (op)
                    OP_CMOV: begin
                        wr_en   = (r_vc != '0);
                        wr_data = r_vb;
                    end
                    OP_LOAD: begin
                        n_res.kind      = K_LOAD;
                        n_res.operand_b = r_vb;
                        n_res.operand_c = r_vc;
                        n_res.dest_reg  = ra;
                    end
                    OP_STORE: begin
                        n_res.kind      = K_STORE;
                        n_res.operand_a = rd_m;
                        n_res.operand_b = r_vb;
                        n_res.operand_c = r_vc;
                    end
                    OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = r_vb + r_vc;
                    end
                    OP_MUL: begin
                        n_acc   = mul_lo;
                        n_state = S_WRB;
                    end
                    OP_DIV: begin
                        if (r_vc == '0) begin
                            n_res.kind = K_DIVFAULT;
                        end else begin
                            n_acc   = r_vb;
                            n_rem   = '0;
                            n_cnt   = '1;
                            n_state = S_DIV;
                        end
                    end
                    OP_NAND: begin
                        wr_en   = 1'b1;
                        wr_data = ~(r_vb & r_vc);
                    end
                    OP_HALT: begin
                        n_res.kind = K_HALT;
                    end
                    OP_MAP: begin
                        n_res.kind      = K_MAP;
                        n_res.operand_c = r_vc;
                        n_res.dest_reg  = rb;
                    end
                    OP_ABANDON: begin
                        n_res.kind      = K_UNMAP;
                        n_res.operand_c = r_vc;
                    end
                    OP_OUT: begin
                        n_res.kind      = K_OUT;
                        n_res.char_out  = r_vc[7:0];
                        n_res.operand_c = r_vc;
                    end
                    OP_IN: begin
                        wr_en   = 1'b1;
                        wr_addr = rc;
                        wr_data = r_item.in_eof ? '1 : {{(WORD_W-8){1'b0}}, r_item.in_char};
                    end
                    OP_LOADP: begin
                        n_res.kind      = K_LOADP;
                        n_res.operand_b = r_vb;
                        n_res.operand_c = r_vc;
                    end
                    OP_LDI: begin
                        wr_en   = 1'b1;
                        wr_addr = r_item.instr_word[27:25];
                        wr_data = {7'b0, r_item.instr_word[24:0]};
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!diff[WORD_W]) begin
                    n_rem = diff[WORD_W-1:0];
                    n_acc = {r_acc[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[WORD_W-1:0];
                    n_acc = {r_acc[WORD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_WRB;
                end
            end
            S_WRB: begin
                wr_en   = 1'b1;
                wr_data = r_acc;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = ld_out || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_vb      <= n_vb;
        r_vc      <= n_vc;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
        r_rd_addr <= rd_addr;
        if (ld_out) begin
            r_out <= r_res;
        end
    end

    a_divzero_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && op == OP_DIV && r_vc == '0) |-> !wr_en)
        else $error("divide by zero wrote a register");

    a_reply_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.data.action == ACT_REPLY) |=> (r_state == S_DONE))
        else $error("write-back did not go straight to result");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_WRB))
        else $error("divider did not finish after last step");

endmodule

`default_nettype wire
